// ===== design/ptd_pkg.sv =====
// ptd_pkg: shared widths, defaults and types for the prime table trial division block
// no dependencies
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int unsigned TableDepthDefault = 131072;

  localparam int unsigned COUNT_W = 18;
  localparam int unsigned INDEX_W = 17;
  localparam int unsigned VALUE_W = 20;
  localparam int unsigned CAND_W  = 50;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } ptd_mod_rsp_t;

endpackage

// ===== design/ptd_table.sv =====
// ptd_table: prime table storage, one write port and one registered read port
// depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_table
  import ptd_pkg::*;
#(
  parameter int unsigned DEPTH = TableDepthDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ptd_mod.sv =====
// ptd_mod: bit-serial restoring remainder of the candidate by one table prime
// depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_mod
  import ptd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CAND_W-1:0]  dividend_i,
  input  logic [VALUE_W-1:0] divisor_i,
  output ptd_mod_rsp_t       rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAND_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CAND_W-1:0]  dvd_q, dvd_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W:0]   diff;

  assign trial = {rem_q, dvd_q[CAND_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(CAND_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[CAND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[VALUE_W-1:0];
      end else begin
        rem_d = trial[VALUE_W-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

// ===== design/prime_table_trial_division_core.sv =====
// sequence: a load writes its table entry at the transfer; a test walks the entries, running each
// nonzero entry below the candidate through the 50-step bit-serial remainder and skipping the rest
// throughput: one item at a time; a new item is taken while a result waits to be taken
// reset: asynchronous active low, clears control state and table_count; table is not cleared
// prime_table_trial_division_core: controller walking the prime table for each test
// depends on ptd_pkg, ptd_table, ptd_mod
`timescale 1ns / 1ps

module prime_table_trial_division_core
  import ptd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [INDEX_W-1:0] entry_index_i,
  input  logic [VALUE_W-1:0] prime_value_i,
  input  logic [CAND_W-1:0]  candidate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               no_factor_found_o,
  output logic [VALUE_W-1:0] divisor_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_WAIT = 5'b00100,
    S_MOD  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      limit_q, limit_d;
  logic [CAND_W-1:0]  cand_q, cand_d;
  logic [VALUE_W-1:0] p_q, p_d;
  logic               res_nff_q, res_nff_d;
  logic [VALUE_W-1:0] res_div_q, res_div_d;
  logic               out_valid_q, out_valid_d;
  logic               out_nff_q, out_nff_d;
  logic [VALUE_W-1:0] out_div_q, out_div_d;

  logic               in_xfer;
  logic               tbl_we;
  logic               tbl_re;
  logic [VALUE_W-1:0] tbl_rdata;
  logic [31:0]        widx_ext;
  logic [31:0]        count_ext;
  logic               mod_start;
  ptd_mod_rsp_t       mod_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign widx_ext   = 32'(entry_index_i);
  assign count_ext  = 32'(count_q);
  assign tbl_we     = in_xfer && (kind_i == KIND_LOAD) && (widx_ext < 32'(TABLE_DEPTH));

  ptd_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i (prime_value_i),
    .re_i    (tbl_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  ptd_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cand_q),
    .divisor_i  (p_q),
    .rsp_o      (mod_rsp)
  );

  always_comb begin
    count_d     = cfg_we_i ? cfg_wdata_i : count_q;
    state_d     = state_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    cand_d      = cand_q;
    p_d         = p_q;
    res_nff_d   = res_nff_q;
    res_div_d   = res_div_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_nff_d   = out_nff_q;
    out_div_d   = out_div_q;
    tbl_re      = 1'b0;
    mod_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (kind_i == KIND_TEST)) begin
          cand_d  = candidate_i;
          idx_d   = '0;
          limit_d = (count_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (idx_q == limit_q) begin
          res_nff_d = 1'b1;
          res_div_d = '0;
          state_d   = S_DONE;
        end else begin
          tbl_re  = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        p_d = tbl_rdata;
        if ((tbl_rdata != '0) && (cand_q > CAND_W'(tbl_rdata))) begin
          mod_start = 1'b1;
          state_d   = S_MOD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_WALK;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem_zero) begin
            res_nff_d = 1'b0;
            res_div_d = p_q;
            state_d   = S_DONE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_WALK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_nff_d   = res_nff_q;
          out_div_d   = res_div_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    p_q       <= p_d;
    res_nff_q <= res_nff_d;
    res_div_q <= res_div_d;
    out_nff_q <= out_nff_d;
    out_div_q <= out_div_d;
  end

  assign out_valid_o       = out_valid_q;
  assign no_factor_found_o = out_nff_q;
  assign divisor_o         = out_div_q;

endmodule

// ===== design/ptd_checker.sv =====
// ptd_checker: port-level assertions for prime_table_trial_division_core, with its bind
// depends on ptd_pkg and prime_table_trial_division_core
`timescale 1ns / 1ps

module ptd_checker
  import ptd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               no_factor_found_o,
  input logic [VALUE_W-1:0] divisor_o
);

  // result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // divisor is zero exactly when no factor was found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (no_factor_found_o == (divisor_o == '0)))
    else $error("divisor and no_factor_found disagree");

  // a load makes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("result after load transfer");

  // a test keeps the input side busy while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_TEST) |=> !in_ready_o)
    else $error("input ready right after test transfer");

endmodule

bind prime_table_trial_division_core ptd_checker u_ptd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .kind_i            (kind_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .no_factor_found_o (no_factor_found_o),
  .divisor_o         (divisor_o)
);

// ===== bench/testbench.sv =====
// testbench: directed and random checks of prime_table_trial_division_core with a small table
// depends on ptd_pkg and prime_table_trial_division_core
`timescale 1ns / 1ps

module testbench;
  import ptd_pkg::*;

  localparam int unsigned TB_DEPTH = 16;
  localparam int unsigned TB_AW = $clog2(TB_DEPTH);
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned WALK_CYCLES = TB_DEPTH * 53 + 8;
  localparam int unsigned HOLD_CYCLES = 3 * WALK_CYCLES;
  localparam int unsigned MAX_GAP = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT =
      4 * (WALK_CYCLES + HOLD_CYCLES + MAX_GAP + SETTLE_CYCLES + 64);
  localparam int unsigned N_PROBES = 25;
  localparam int unsigned N_PHASES = 4;
  localparam int unsigned PHASE_ITEMS = 15;

  typedef struct packed {
    logic               no_factor;
    logic [VALUE_W-1:0] divisor;
  } verdict_t;

  typedef struct packed {
    logic               set_cnt;
    logic [COUNT_W-1:0] cnt;
    logic               kind;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic [CAND_W-1:0]  cand;
    logic               typed;
    logic               exp_nf;
    logic [VALUE_W-1:0] exp_div;
  } probe_row_t;

  localparam int unsigned SMALL_PRIMES [TB_DEPTH] =
      '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

  // count stays at its reset value for the first two rows
  localparam probe_row_t PROBE_ROWS [N_PROBES] = '{
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd6, 1'b1, 1'b1, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'h3_FFFF_FFFF_FFFF, 1'b1, 1'b1, 20'd0},
    '{1'b1, 18'(TB_DEPTH), KIND_TEST, 17'd0, 20'd0, 50'd0, 1'b1, 1'b1, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd1, 1'b1, 1'b1, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd2, 1'b1, 1'b1, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd4, 1'b1, 1'b0, 20'd2},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd53, 1'b1, 1'b1, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd2809, 1'b1, 1'b0, 20'd53},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'h3_FFFF_FFFF_FFFF, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'h2_0000_0000_0000, 1'b1, 1'b0, 20'd2},
    '{1'b0, 18'd0, KIND_LOAD, 17'd0, 20'd0, 50'd0, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd4, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd6, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_LOAD, 17'(TB_DEPTH), 20'd7, 50'd0, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_LOAD, 17'h1FFFF, 20'hFFFFF, 50'd0, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd1048575, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_LOAD, 17'd0, 20'd2, 50'd0, 1'b0, 1'b0, 20'd0},
    '{1'b1, 18'h3FFFF, KIND_TEST, 17'd0, 20'd0, 50'd2491, 1'b0, 1'b0, 20'd0},
    '{1'b1, 18'd1, KIND_TEST, 17'd0, 20'd0, 50'd9, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd10, 1'b0, 1'b0, 20'd0},
    '{1'b1, 18'(TB_DEPTH - 1), KIND_TEST, 17'd0, 20'd0, 50'd3127, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_TEST, 17'd0, 20'd0, 50'd106, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_LOAD, 17'd15, 20'd1048573, 50'd0, 1'b0, 1'b0, 20'd0},
    '{1'b1, 18'(TB_DEPTH), KIND_TEST, 17'd0, 20'd0, 50'd1099505336329, 1'b0, 1'b0, 20'd0},
    '{1'b0, 18'd0, KIND_LOAD, 17'd15, 20'd53, 50'd0, 1'b0, 1'b0, 20'd0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = KIND_LOAD;
  logic [INDEX_W-1:0] entry_index = '0;
  logic [VALUE_W-1:0] prime_value = '0;
  logic [CAND_W-1:0]  candidate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               no_factor_found;
  logic [VALUE_W-1:0] divisor;

  bit [VALUE_W-1:0] loaded_primes [TB_DEPTH];
  int unsigned      walk_len = 0;
  verdict_t         pending_verdicts [$];
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      hold_reqs = 0;
  int unsigned      holds_done = 0;

  prime_table_trial_division_core #(
    .TABLE_DEPTH(TB_DEPTH)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .entry_index_i    (entry_index),
    .prime_value_i    (prime_value),
    .candidate_i      (candidate),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .no_factor_found_o(no_factor_found),
    .divisor_o        (divisor)
  );

  always #6 clk_i = ~clk_i;

  function automatic verdict_t trial_divide(input logic [CAND_W-1:0] n);
    verdict_t        v;
    int unsigned     lim;
    longint unsigned num;
    longint unsigned p;
    v.no_factor = 1'b1;
    v.divisor = '0;
    num = 64'(n);
    lim = (walk_len > TB_DEPTH) ? TB_DEPTH : walk_len;
    for (int unsigned i = 0; i < lim; i++) begin
      p = 64'(loaded_primes[i]);
      if (p != 0 && num > p && (num % p) == 0) begin
        v.no_factor = 1'b0;
        v.divisor = VALUE_W'(p);
        return v;
      end
    end
    return v;
  endfunction

  function automatic logic [CAND_W-1:0] pick_candidate();
    longint unsigned a;
    longint unsigned b;
    a = 64'(loaded_primes[$urandom_range(0, TB_DEPTH - 1)]);
    b = 64'(loaded_primes[$urandom_range(0, TB_DEPTH - 1)]);
    case ($urandom_range(0, 8))
      0: return CAND_W'($urandom_range(0, 3));
      1: return CAND_W'({$urandom, $urandom});
      2: return CAND_W'(a);
      3: return CAND_W'(a * $urandom_range(1, 64));
      4: return CAND_W'(a * $urandom_range(1, 32'h3FFF_FFFF));
      5: return CAND_W'(a * b);
      6: return CAND_W'($urandom_range(0, 5000));
      7: return CAND_W'(a * b * $urandom_range(1, 1000));
      default: return {CAND_W{1'b1}} ^ CAND_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic offer_item(input logic kind_v, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val, input logic [CAND_W-1:0] cand,
                            input logic typed, input verdict_t typed_v);
    in_valid <= 1'b1;
    kind <= kind_v;
    entry_index <= (kind_v == KIND_LOAD) ? idx : INDEX_W'($urandom);
    prime_value <= (kind_v == KIND_LOAD) ? val : VALUE_W'($urandom);
    candidate <= (kind_v == KIND_TEST) ? cand : CAND_W'({$urandom, $urandom});
    do @(posedge clk_i); while (in_ready !== 1'b1);
    if (kind_v == KIND_LOAD) begin
      if (idx < TB_DEPTH) loaded_primes[idx[TB_AW-1:0]] = val;
    end else begin
      pending_verdicts.push_back(typed ? typed_v : trial_divide(cand));
    end
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic set_walk_len(input logic [COUNT_W-1:0] cnt);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    walk_len = 32'(cnt);
    burst_left = 0;
  endtask

  initial begin : stimulus
    probe_row_t         row;
    verdict_t           typed_v;
    verdict_t           none_v;
    logic [COUNT_W-1:0] cnt;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    none_v = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry is loaded before any walk can reach it
    for (int i = 0; i < TB_DEPTH; i++) begin
      pace_sender();
      offer_item(KIND_LOAD, INDEX_W'(i), VALUE_W'(SMALL_PRIMES[i]), '0, 1'b0, none_v);
    end

    for (int i = 0; i < N_PROBES; i++) begin
      row = PROBE_ROWS[i];
      if (row.set_cnt) set_walk_len(row.cnt);
      pace_sender();
      typed_v.no_factor = row.exp_nf;
      typed_v.divisor = row.exp_div;
      offer_item(row.kind, row.idx, row.val, row.cand, row.typed, typed_v);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: cnt = COUNT_W'(TB_DEPTH);
        1: cnt = COUNT_W'($urandom_range(0, TB_DEPTH));
        2: cnt = COUNT_W'(COUNT_MAX);
        default: cnt = COUNT_W'($urandom_range(0, COUNT_MAX));
      endcase
      set_walk_len(cnt);
      if (ph % 2 == 0) hold_reqs++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pace_sender();
        if ($urandom_range(0, 2) == 0) begin
          idx = ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom)
                                            : INDEX_W'($urandom_range(0, TB_DEPTH - 1));
          case ($urandom_range(0, 9))
            0, 1, 2: val = VALUE_W'(SMALL_PRIMES[$urandom_range(0, TB_DEPTH - 1)]);
            3, 4, 5: val = VALUE_W'($urandom_range(2, 200));
            6, 7, 8: val = VALUE_W'($urandom);
            default: val = ($urandom_range(0, 3) == 0) ? '0 : {VALUE_W{1'b1}};
          endcase
          offer_item(KIND_LOAD, idx, val, '0, 1'b0, none_v);
        end else begin
          offer_item(KIND_TEST, '0, '0, pick_candidate(), 1'b0, none_v);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (WALK_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_pacing
    int unsigned span;
    int unsigned style;
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        style = $urandom_range(0, 3);
        span = (style == 1) ? $urandom_range(1, 6) : $urandom_range(1, 24);
        for (int c = 0; c < span; c++) begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'b0;
            2: out_ready <= c[0];
            default: out_ready <= 1'($urandom);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_verdicts
    verdict_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none expected, no_factor_found %0b divisor %0d",
                 $time, no_factor_found, divisor);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (no_factor_found !== want.no_factor) begin
          $display("%0t: no_factor_found expected %0b actual %0b",
                   $time, want.no_factor, no_factor_found);
          mismatches++;
        end
        if (divisor !== want.divisor) begin
          $display("%0t: divisor expected %0d actual %0d", $time, want.divisor, divisor);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
